### hw/rtl/assert_macros.svh
// Assertion macros used by the checker module of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AKCT_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define AKCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/akct_pkg.sv
// Shared types, constants and functions of the address keyed counter table.
package akct_pkg;

	localparam int TableDepthDef = 4096;
	localparam int ProbeLimitDef = 64;
	localparam int KeyShiftDef   = 4;
	localparam int QueueDepth    = 4;

	localparam int KeyW   = 64;
	localparam int CntW   = 32;
	localparam int UsedW  = 17;
	localparam int InDataW  = 72;
	localparam int InUserW  = 2;
	localparam int OutDataW = 216;
	localparam int OutUserW = 3;

	// Input mode codes.
	localparam logic [1:0] MODE_COUNT  = 2'd0;
	localparam logic [1:0] MODE_LOOKUP = 2'd1;
	localparam logic [1:0] MODE_CLEAR  = 2'd2;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_IGNORED = 3'd0,
		ST_HIT     = 3'd1,
		ST_NEW     = 3'd2,
		ST_FULL    = 3'd3,
		ST_FOUND   = 3'd4,
		ST_MISS    = 3'd5,
		ST_CLEARED = 3'd6
	} status_t;

	// Command kinds after classification.
	typedef enum logic [1:0] {
		CMD_COUNT,
		CMD_LOOKUP,
		CMD_CLEAR,
		CMD_IGNORE
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [KeyW-1:0]   key;
		logic              marked;
		logic              young;
	} cmd_t;

	typedef struct packed {
		logic [CntW-1:0] refs;
		logic [CntW-1:0] marked;
		logic [CntW-1:0] unmarked;
		logic [CntW-1:0] young;
		logic [CntW-1:0] old;
	} cnt_t;

	typedef struct packed {
		logic            valid;
		logic [KeyW-1:0] key;
		cnt_t            cnt;
	} entry_t;

	typedef struct packed {
		status_t          status;
		cnt_t             cnt;
		logic [UsedW-1:0] used;
		logic [CntW-1:0]  full;
	} res_t;

	// Back end sequencer states.
	typedef enum logic [2:0] {
		BK_INIT,
		BK_IDLE,
		BK_READ,
		BK_CHECK,
		BK_SWEEP,
		BK_RESP
	} bk_state_t;

	// Increment that sticks at the counter maximum.
	function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
		return (&v) ? v : v + {{(CntW-1){1'b0}}, 1'b1};
	endfunction

endpackage

### hw/rtl/akct_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module akct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### hw/rtl/akct_front.sv
// Front end: accepts input transactions and classifies them into commands.
module akct_front (
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [akct_pkg::InDataW-1:0]   s_axis_tdata,
	input  logic [akct_pkg::InUserW-1:0]   s_axis_tuser,
	input  logic                           init_done,
	input  logic                           queue_ready,
	output logic                           push,
	output akct_pkg::cmd_t                 cmd
);

	logic [akct_pkg::KeyW-1:0] key;
	logic                      key_zero;

	assign key      = s_axis_tdata[akct_pkg::KeyW-1:0];
	assign key_zero = (key == '0);

	// Accept only after the clearing pass and while the queue has room.
	assign s_axis_tready = init_done && queue_ready;
	assign push          = s_axis_tvalid && s_axis_tready;

	// Classify the mode; a zero key in count or lookup mode, or the unused mode, is ignored.
	always_comb begin
		cmd.key    = key;
		cmd.marked = s_axis_tdata[akct_pkg::KeyW];
		cmd.young  = s_axis_tdata[akct_pkg::KeyW+1];
		case (s_axis_tuser)
			akct_pkg::MODE_COUNT:  cmd.kind = key_zero ? akct_pkg::CMD_IGNORE
			                                           : akct_pkg::CMD_COUNT;
			akct_pkg::MODE_LOOKUP: cmd.kind = key_zero ? akct_pkg::CMD_IGNORE
			                                           : akct_pkg::CMD_LOOKUP;
			akct_pkg::MODE_CLEAR:  cmd.kind = akct_pkg::CMD_CLEAR;
			default:               cmd.kind = akct_pkg::CMD_IGNORE;
		endcase
	end

endmodule

### hw/rtl/akct_fifo.sv
// Short command queue between the front end and the back end.
module akct_fifo #(
	parameter int DEPTH = akct_pkg::QueueDepth
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  akct_pkg::cmd_t push_data,
	output logic           ready,
	input  logic           pop,
	output logic           empty,
	output akct_pkg::cmd_t pop_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	akct_pkg::cmd_t slot_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + {{(AW-1){1'b0}}, 1'b1};
	endfunction

	assign ready    = (count_q != CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = slot_q[rd_ptr_q];

	// Storage slots.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + {{(CW-1){1'b0}}, 1'b1};
			end else if (pop && !push) begin
				count_q <= count_q - {{(CW-1){1'b0}}, 1'b1};
			end
		end
	end

endmodule

### hw/rtl/akct_back.sv
// Back end: probes the table memory, updates entries and holds the result.
module akct_back #(
	parameter int TABLE_DEPTH = akct_pkg::TableDepthDef,
	parameter int PROBE_LIMIT = akct_pkg::ProbeLimitDef,
	parameter int KEY_SHIFT   = akct_pkg::KeyShiftDef
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_empty,
	input  akct_pkg::cmd_t cmd,
	output logic           cmd_pop,
	output logic           init_done,
	output logic           res_valid,
	input  logic           res_ready,
	output akct_pkg::res_t res
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int PW    = (PROBE_LIMIT > 1) ? $clog2(PROBE_LIMIT) : 1;
	localparam int EW    = $bits(akct_pkg::entry_t);

	akct_pkg::bk_state_t       state_q, state_d;
	akct_pkg::cmd_t            cmd_q;
	logic [IDX_W-1:0]          idx_q;
	logic [PW-1:0]             probe_q;
	logic [IDX_W-1:0]          sweep_q;
	akct_pkg::status_t         res_status_q, res_status_d;
	akct_pkg::cnt_t            res_cnt_q;
	logic [akct_pkg::UsedW-1:0] used_q;
	logic [akct_pkg::CntW-1:0]  full_q;
	logic                      out_valid_q;
	akct_pkg::res_t            out_q;

	logic                      ram_we;
	logic [IDX_W-1:0]          ram_waddr;
	akct_pkg::entry_t          ram_wdata;
	logic [EW-1:0]             ram_rdata;
	akct_pkg::entry_t          rd_ent;

	logic                      hit, empty_slot, last_probe, sweep_last, out_free;
	akct_pkg::cnt_t            base_cnt, upd_cnt;

	assign rd_ent     = akct_pkg::entry_t'(ram_rdata);
	assign hit        = rd_ent.valid && (rd_ent.key == cmd_q.key);
	assign empty_slot = !rd_ent.valid;
	assign last_probe = (probe_q == PW'(PROBE_LIMIT - 1));
	assign sweep_last = &sweep_q;
	assign out_free   = !out_valid_q || res_ready;
	assign init_done  = (state_q != akct_pkg::BK_INIT);

	// Table memory: one entry per word, read address follows the probe index.
	akct_ram #(
		.WIDTH(EW),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	// Counters of the entry after this count: from zero for a new claim.
	always_comb begin
		base_cnt = hit ? rd_ent.cnt : '0;
		upd_cnt.refs     = akct_pkg::sat_inc(base_cnt.refs);
		upd_cnt.marked   = cmd_q.marked ? akct_pkg::sat_inc(base_cnt.marked)
		                                : base_cnt.marked;
		upd_cnt.unmarked = cmd_q.marked ? base_cnt.unmarked
		                                : akct_pkg::sat_inc(base_cnt.unmarked);
		upd_cnt.young    = cmd_q.young ? akct_pkg::sat_inc(base_cnt.young)
		                               : base_cnt.young;
		upd_cnt.old      = cmd_q.young ? base_cnt.old
		                               : akct_pkg::sat_inc(base_cnt.old);
	end

	// Next state of the sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			akct_pkg::BK_INIT: begin
				if (sweep_last) state_d = akct_pkg::BK_IDLE;
			end
			akct_pkg::BK_IDLE: begin
				if (!cmd_empty) begin
					case (cmd.kind)
						akct_pkg::CMD_CLEAR:  state_d = akct_pkg::BK_SWEEP;
						akct_pkg::CMD_IGNORE: state_d = akct_pkg::BK_RESP;
						default:              state_d = akct_pkg::BK_READ;
					endcase
				end
			end
			akct_pkg::BK_READ:  state_d = akct_pkg::BK_CHECK;
			akct_pkg::BK_CHECK: begin
				if (hit || empty_slot || last_probe) state_d = akct_pkg::BK_RESP;
				else                                 state_d = akct_pkg::BK_READ;
			end
			akct_pkg::BK_SWEEP: begin
				if (sweep_last) state_d = akct_pkg::BK_RESP;
			end
			akct_pkg::BK_RESP: begin
				if (out_free) state_d = akct_pkg::BK_IDLE;
			end
			default: state_d = akct_pkg::BK_INIT;
		endcase
	end

	// Outputs of the sequencer: queue pop, memory write and result status.
	always_comb begin
		cmd_pop         = 1'b0;
		ram_we          = 1'b0;
		ram_waddr       = sweep_q;
		ram_wdata       = '0;
		ram_wdata.valid = 1'b0;
		res_status_d    = akct_pkg::ST_IGNORED;
		case (state_q)
			akct_pkg::BK_INIT,
			akct_pkg::BK_SWEEP: begin
				ram_we = 1'b1;
				res_status_d = akct_pkg::ST_CLEARED;
			end
			akct_pkg::BK_IDLE: begin
				cmd_pop = !cmd_empty;
			end
			akct_pkg::BK_CHECK: begin
				ram_waddr = idx_q;
				ram_wdata.valid = 1'b1;
				ram_wdata.key   = cmd_q.key;
				ram_wdata.cnt   = upd_cnt;
				if (cmd_q.kind == akct_pkg::CMD_LOOKUP) begin
					if (hit) res_status_d = akct_pkg::ST_FOUND;
					else     res_status_d = akct_pkg::ST_MISS;
				end else begin
					ram_we = hit || empty_slot;
					if (hit)             res_status_d = akct_pkg::ST_HIT;
					else if (empty_slot) res_status_d = akct_pkg::ST_NEW;
					else                 res_status_d = akct_pkg::ST_FULL;
				end
			end
			default: begin
			end
		endcase
	end

	// Control registers, totals and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= akct_pkg::BK_INIT;
			sweep_q     <= '0;
			used_q      <= '0;
			full_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// A new result fills the output register; an accepted one empties it.
			if (state_q == akct_pkg::BK_RESP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (res_valid && res_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				akct_pkg::BK_INIT: begin
					sweep_q <= sweep_q + {{(IDX_W-1){1'b0}}, 1'b1};
				end
				akct_pkg::BK_SWEEP: begin
					sweep_q <= sweep_q + {{(IDX_W-1){1'b0}}, 1'b1};
					if (sweep_last) begin
						used_q <= '0;
						full_q <= '0;
					end
				end
				akct_pkg::BK_CHECK: begin
					if (cmd_q.kind == akct_pkg::CMD_COUNT) begin
						if (!hit && empty_slot) begin
							used_q <= used_q + {{(akct_pkg::UsedW-1){1'b0}}, 1'b1};
						end else if (!hit && last_probe) begin
							full_q <= akct_pkg::sat_inc(full_q);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Payload registers of the current command and its result.
	always_ff @(posedge clk) begin
		case (state_q)
			akct_pkg::BK_IDLE: begin
				cmd_q        <= cmd;
				idx_q        <= cmd.key[KEY_SHIFT +: IDX_W];
				probe_q      <= '0;
				res_status_q <= akct_pkg::ST_IGNORED;
				res_cnt_q    <= '0;
			end
			akct_pkg::BK_CHECK: begin
				idx_q   <= idx_q + {{(IDX_W-1){1'b0}}, 1'b1};
				probe_q <= probe_q + {{(PW-1){1'b0}}, 1'b1};
				res_status_q <= res_status_d;
				if (hit && cmd_q.kind == akct_pkg::CMD_LOOKUP) begin
					res_cnt_q <= rd_ent.cnt;
				end else if (cmd_q.kind == akct_pkg::CMD_COUNT && (hit || empty_slot)) begin
					res_cnt_q <= upd_cnt;
				end else begin
					res_cnt_q <= '0;
				end
			end
			akct_pkg::BK_SWEEP: begin
				res_status_q <= res_status_d;
				res_cnt_q    <= '0;
			end
			akct_pkg::BK_RESP: begin
				if (out_free) begin
					out_q.status <= res_status_q;
					out_q.cnt    <= res_cnt_q;
					out_q.used   <= used_q;
					out_q.full   <= full_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

endmodule

### hw/rtl/address_keyed_counter_table_unit.sv
// A count or lookup passes through the READ and CHECK states once per probe, then through RESP.
// Ignored items go straight to RESP; a clear item sweeps the table (one entry per cycle), then RESP.
// The back end handles one item at a time, probing the single table memory with registered read.
// Up to four accepted items wait in the command queue while the back end works or stalls.
// Reset is asynchronous; after it a clearing pass over the whole table holds tready low.
module address_keyed_counter_table_unit #(
	parameter int TABLE_DEPTH = akct_pkg::TableDepthDef,
	parameter int PROBE_LIMIT = akct_pkg::ProbeLimitDef,
	parameter int KEY_SHIFT   = akct_pkg::KeyShiftDef
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// key[63:0], holder_marked[64], holder_young[65], zero pad above.
	input  logic [akct_pkg::InDataW-1:0]  s_axis_tdata,
	// mode[1:0].
	input  logic [akct_pkg::InUserW-1:0]  s_axis_tuser,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// ref_count[31:0], marked_count[63:32], unmarked_count[95:64], young_count[127:96],
	// old_count[159:128], entries_used[176:160], full_events[208:177], zero pad above.
	output logic [akct_pkg::OutDataW-1:0] m_axis_tdata,
	// status[2:0].
	output logic [akct_pkg::OutUserW-1:0] m_axis_tuser
);

	logic           push, queue_ready, pop, queue_empty, init_done;
	akct_pkg::cmd_t push_cmd, pop_cmd;
	akct_pkg::res_t res;

	akct_front u_front (
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.init_done    (init_done),
		.queue_ready  (queue_ready),
		.push         (push),
		.cmd          (push_cmd)
	);

	akct_fifo #(
		.DEPTH(akct_pkg::QueueDepth)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_cmd),
		.ready    (queue_ready),
		.pop      (pop),
		.empty    (queue_empty),
		.pop_data (pop_cmd)
	);

	akct_back #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.PROBE_LIMIT(PROBE_LIMIT),
		.KEY_SHIFT  (KEY_SHIFT)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_empty(queue_empty),
		.cmd      (pop_cmd),
		.cmd_pop  (pop),
		.init_done(init_done),
		.res_valid(m_axis_tvalid),
		.res_ready(m_axis_tready),
		.res      (res)
	);

	// Pack the result transaction, first field in the lowest bits.
	assign m_axis_tuser = res.status;
	assign m_axis_tdata = {7'd0, res.full, res.used, res.cnt.old, res.cnt.young,
	                       res.cnt.unmarked, res.cnt.marked, res.cnt.refs};

endmodule

### hw/rtl/akct_checker.sv
// Port-level checker of the counter table unit and its bind statement.
`include "assert_macros.svh"

module akct_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [akct_pkg::OutDataW-1:0] m_axis_tdata,
	input logic [akct_pkg::OutUserW-1:0] m_axis_tuser
);

	logic no_entry;

	// Statuses that involve no table entry.
	assign no_entry = (m_axis_tuser == akct_pkg::ST_IGNORED) ||
	                  (m_axis_tuser == akct_pkg::ST_FULL) ||
	                  (m_axis_tuser == akct_pkg::ST_MISS) ||
	                  (m_axis_tuser == akct_pkg::ST_CLEARED);

	// A stalled result transaction holds its payload.
	`AKCT_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")
	// Only defined status codes are produced.
	`AKCT_ASSERT_IMPLY(a_status_range, clk, arst_n, m_axis_tvalid, m_axis_tuser <= akct_pkg::ST_CLEARED, "status out of range")
	// Results without an entry carry zero counters.
	`AKCT_ASSERT_IMPLY(a_zero_cnt, clk, arst_n, m_axis_tvalid && no_entry, m_axis_tdata[159:0] == '0, "counters nonzero without an entry")
	// A clear leaves both totals at zero.
	`AKCT_ASSERT_IMPLY(a_clear_totals, clk, arst_n, m_axis_tvalid && (m_axis_tuser == akct_pkg::ST_CLEARED), m_axis_tdata[208:160] == '0, "totals not zero after clear")
	// A newly claimed entry has exactly one reference.
	`AKCT_ASSERT_IMPLY(a_new_one_ref, clk, arst_n, m_axis_tvalid && (m_axis_tuser == akct_pkg::ST_NEW), m_axis_tdata[31:0] == 32'd1, "new entry without a single reference")

endmodule

bind address_keyed_counter_table_unit akct_checker u_akct_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser)
);
